### src/tss_pkg.sv
package tss_pkg;

    localparam int REG_W = 12;
    localparam int CMD_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DEF_AVG_SAMPLES = 4;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam logic [CMD_W-1:0] CMD_PRESSURE = 8'hB0;
    localparam logic [CMD_W-1:0] CMD_XCHAN = 8'hD0;
    localparam logic [CMD_W-1:0] CMD_YCHAN = 8'h90;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_XCHAN_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XCHAN_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YCHAN_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YCHAN_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAX = 3'd6;

    localparam logic [REG_W-1:0] RST_THRESHOLD = 12'd50;
    localparam logic [REG_W-1:0] RST_RAW_MIN = 12'd200;
    localparam logic [REG_W-1:0] RST_RAW_MAX = 12'd3900;
    localparam logic [REG_W-1:0] RST_COL_MAX = 12'd319;
    localparam logic [REG_W-1:0] RST_ROW_MAX = 12'd239;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRESS,
        ST_XCH,
        ST_YCH,
        ST_AVGX,
        ST_AVGY,
        ST_MAPC,
        ST_MAPR,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic             cmd_valid;
        logic [CMD_W-1:0] cmd_byte;
        logic             event_valid;
        logic             pressed;
        logic [REG_W-1:0] screen_x;
        logic [REG_W-1:0] screen_y;
    } res_t;

endpackage

### src/tss_muldiv.sv
module tss_muldiv #(
    parameter int AW = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [AW-1:0]                   a,
    input  logic [tss_pkg::REG_W-1:0]       b,
    input  logic [tss_pkg::REG_W-1:0]       d,
    output logic                            done,
    output logic [AW+tss_pkg::REG_W-1:0]    q
);
    import tss_pkg::*;

    localparam int PW = AW + REG_W;
    localparam int CNTW = $clog2(PW);

    md_state_t          state_reg, state_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [PW-1:0]      mcand_reg, mcand_next;
    logic [REG_W-1:0]   mplier_reg, mplier_next;
    logic [REG_W-1:0]   div_reg, div_next;
    logic [REG_W-1:0]   rem_reg, rem_next;
    logic [REG_W:0]     rem_sh;
    logic [REG_W:0]     rem_sub;
    logic               fits;

    assign rem_sh = {rem_reg, acc_reg[PW-1]};
    assign fits = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    // Shift-and-add multiply one multiplier bit a cycle, then restoring
    // division one quotient bit a cycle; the quotient shifts into acc_reg.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        div_next = div_reg;
        rem_next = rem_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_next = '0;
                    mcand_next = PW'(a);
                    mplier_next = b;
                    div_next = d;
                    rem_next = '0;
                    cnt_next = CNTW'(REG_W - 1);
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[REG_W-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next = CNTW'(PW - 1);
                    state_next = MD_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            MD_DIV:
            begin
                rem_next = fits ? rem_sub[REG_W-1:0] : rem_sh[REG_W-1:0];
                acc_next = {acc_reg[PW-2:0], fits};
                if (cnt_reg == '0)
                begin
                    done_next = 1'b1;
                    state_next = MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign q = acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == MD_IDLE))
        else $error("Operation started while the unit was busy.");

    a_div_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MD_DIV && cnt_reg == '0) |=> done_reg)
        else $error("Last division step did not signal completion.");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == MD_DIV))
        else $error("Completion signaled outside the division phase.");

endmodule

### src/touch_sample_sequencer_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    op, pen_irq_n, reply_word
// out       output     out_valid / out_ready  cmd_valid, cmd_byte, event_valid,
//                                             pressed, screen_x, screen_y
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A poll or a reply that does not end a sequence pushes its word straight into the output queue.
// The reply that ends the last X/Y pair starts two averages and two mappings on the
// shared serial unit, each a multiply followed by a restoring division; a mapping
// of a clamped reading skips the unit.
// Input stalls during that work and while the two-word output queue is full.
// Reset clears the sequence and loads the register defaults.
module touch_sample_sequencer_top #(
    parameter int AVG_SAMPLES = tss_pkg::DEF_AVG_SAMPLES,
    parameter int SAMPLE_BITS = tss_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic                            pen_irq_n,
    input  logic [15:0]                     reply_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            cmd_valid,
    output logic [tss_pkg::CMD_W-1:0]       cmd_byte,
    output logic                            event_valid,
    output logic                            pressed,
    output logic [tss_pkg::REG_W-1:0]       screen_x,
    output logic [tss_pkg::REG_W-1:0]       screen_y,
    input  logic                            cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tss_pkg::REG_W-1:0]       cfg_data
);
    import tss_pkg::*;

    localparam int SMPW = (SAMPLE_BITS < 13) ? SAMPLE_BITS : 13;
    localparam int SUMW = SMPW + $clog2(AVG_SAMPLES);
    localparam int AW = (SUMW > REG_W) ? SUMW : REG_W;
    localparam int PW = AW + REG_W;
    localparam int CW = $clog2(AVG_SAMPLES + 1);
    localparam int CMPW = (SMPW > REG_W) ? SMPW : REG_W;

    logic [REG_W-1:0]   thr_reg, xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [REG_W-1:0]   colmax_reg, rowmax_reg;

    seq_state_t         state_reg, state_next;
    logic [CW-1:0]      pair_reg, pair_next;
    logic [CW-1:0]      pair_inc;
    logic [SUMW-1:0]    sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [SMPW-1:0]    avgx_reg, avgx_next, avgy_reg, avgy_next;
    logic [REG_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic               launched_reg, launched_next;

    res_t               e0_reg, e1_reg;
    logic [1:0]         cnt_reg;
    logic               push, pop, accept;
    res_t               push_data;

    logic [SMPW-1:0]    sample;
    logic [CMPW-1:0]    map_v, map_lo, map_hi, map_diff;
    logic [REG_W-1:0]   map_top;

    logic               md_start, md_done;
    logic [AW-1:0]      md_a;
    logic [REG_W-1:0]   md_b, md_d;
    logic [PW-1:0]      md_q;

    tss_muldiv #(
        .AW(AW)
    ) u_muldiv (
        .clk(clk),
        .rst_n(rst_n),
        .start(md_start),
        .a(md_a),
        .b(md_b),
        .d(md_d),
        .done(md_done),
        .q(md_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= RST_THRESHOLD;
            xmin_reg <= RST_RAW_MIN;
            xmax_reg <= RST_RAW_MAX;
            ymin_reg <= RST_RAW_MIN;
            ymax_reg <= RST_RAW_MAX;
            colmax_reg <= RST_COL_MAX;
            rowmax_reg <= RST_ROW_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data;
                REG_XCHAN_MIN: xmin_reg <= cfg_data;
                REG_XCHAN_MAX: xmax_reg <= cfg_data;
                REG_YCHAN_MIN: ymin_reg <= cfg_data;
                REG_YCHAN_MAX: ymax_reg <= cfg_data;
                REG_COL_MAX: colmax_reg <= cfg_data;
                REG_ROW_MAX: rowmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sample = reply_word[3 +: SMPW];
    assign in_ready = (state_reg inside {ST_IDLE, ST_PRESS, ST_XCH, ST_YCH})
                      && (cnt_reg != 2'd2);
    assign accept = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign pair_inc = pair_reg + CW'(1);

    // The column comes from the Y average and the row from the X average.
    always_comb
    begin
        if (state_reg == ST_MAPC)
        begin
            map_v = CMPW'(avgy_reg);
            map_lo = CMPW'(ymin_reg);
            map_hi = CMPW'(ymax_reg);
            map_top = colmax_reg;
        end
        else
        begin
            map_v = CMPW'(avgx_reg);
            map_lo = CMPW'(xmin_reg);
            map_hi = CMPW'(xmax_reg);
            map_top = rowmax_reg;
        end
        map_diff = map_v - map_lo;
    end

    always_comb
    begin
        state_next = state_reg;
        pair_next = pair_reg;
        sumx_next = sumx_reg;
        sumy_next = sumy_reg;
        avgx_next = avgx_reg;
        avgy_next = avgy_reg;
        col_next = col_reg;
        row_next = row_reg;
        launched_next = launched_reg;
        push = 1'b0;
        push_data = '0;
        md_start = 1'b0;
        md_a = '0;
        md_b = '0;
        md_d = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    if (op == OP_POLL)
                    begin
                        if (pen_irq_n)
                        begin
                            push_data.event_valid = 1'b1;
                        end
                        else
                        begin
                            push_data.cmd_valid = 1'b1;
                            push_data.cmd_byte = CMD_PRESSURE;
                            state_next = ST_PRESS;
                        end
                    end
                end
            end
            ST_PRESS:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    if (op == OP_POLL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (CMPW'(sample) < CMPW'(thr_reg))
                    begin
                        push_data.event_valid = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pair_next = '0;
                        sumx_next = '0;
                        sumy_next = '0;
                        push_data.cmd_valid = 1'b1;
                        push_data.cmd_byte = CMD_XCHAN;
                        state_next = ST_XCH;
                    end
                end
            end
            ST_XCH:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    if (op == OP_POLL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sumx_next = sumx_reg + SUMW'(sample);
                        push_data.cmd_valid = 1'b1;
                        push_data.cmd_byte = CMD_YCHAN;
                        state_next = ST_YCH;
                    end
                end
            end
            ST_YCH:
            begin
                if (accept)
                begin
                    if (op == OP_POLL)
                    begin
                        push = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        sumy_next = sumy_reg + SUMW'(sample);
                        if (pair_inc == CW'(AVG_SAMPLES))
                        begin
                            pair_next = '0;
                            state_next = ST_AVGX;
                        end
                        else
                        begin
                            pair_next = pair_inc;
                            push = 1'b1;
                            push_data.cmd_valid = 1'b1;
                            push_data.cmd_byte = CMD_XCHAN;
                            state_next = ST_XCH;
                        end
                    end
                end
            end
            ST_AVGX, ST_AVGY:
            begin
                md_a = (state_reg == ST_AVGX) ? AW'(sumx_reg) : AW'(sumy_reg);
                md_b = REG_W'(1);
                md_d = REG_W'(AVG_SAMPLES);
                md_start = !launched_reg;
                if (md_start)
                begin
                    launched_next = 1'b1;
                end
                if (md_done)
                begin
                    launched_next = 1'b0;
                    if (state_reg == ST_AVGX)
                    begin
                        avgx_next = md_q[SMPW-1:0];
                        state_next = ST_AVGY;
                    end
                    else
                    begin
                        avgy_next = md_q[SMPW-1:0];
                        state_next = ST_MAPC;
                    end
                end
            end
            ST_MAPC, ST_MAPR:
            begin
                md_a = AW'(map_diff[REG_W-1:0]);
                md_b = map_top;
                md_d = map_hi[REG_W-1:0] - map_lo[REG_W-1:0];
                if (!launched_reg && (map_v <= map_lo || map_v >= map_hi))
                begin
                    if (state_reg == ST_MAPC)
                    begin
                        col_next = (map_v <= map_lo) ? '0 : map_top;
                        state_next = ST_MAPR;
                    end
                    else
                    begin
                        row_next = (map_v <= map_lo) ? '0 : map_top;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    md_start = !launched_reg;
                    if (md_start)
                    begin
                        launched_next = 1'b1;
                    end
                    if (md_done)
                    begin
                        launched_next = 1'b0;
                        if (state_reg == ST_MAPC)
                        begin
                            col_next = md_q[REG_W-1:0];
                            state_next = ST_MAPR;
                        end
                        else
                        begin
                            row_next = md_q[REG_W-1:0];
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (cnt_reg != 2'd2 || pop)
                begin
                    push = 1'b1;
                    push_data.event_valid = 1'b1;
                    push_data.pressed = 1'b1;
                    push_data.screen_x = col_reg;
                    push_data.screen_y = row_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pair_reg <= '0;
            sumx_reg <= '0;
            sumy_reg <= '0;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pair_reg <= pair_next;
            sumx_reg <= sumx_next;
            sumy_reg <= sumy_next;
            launched_reg <= launched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avgx_reg <= avgx_next;
        avgy_reg <= avgy_next;
        col_reg <= col_next;
        row_reg <= row_next;
    end

    // Output queue: e0_reg is the word on the port, e1_reg the one behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
            begin
                e0_reg <= push_data;
            end
            else
            begin
                e0_reg <= e1_reg;
                e1_reg <= push_data;
            end
        end
        else if (pop)
        begin
            e0_reg <= e1_reg;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                e0_reg <= push_data;
            end
            else
            begin
                e1_reg <= push_data;
            end
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign cmd_valid = e0_reg.cmd_valid;
    assign cmd_byte = e0_reg.cmd_byte;
    assign event_valid = e0_reg.event_valid;
    assign pressed = e0_reg.pressed;
    assign screen_x = e0_reg.screen_x;
    assign screen_y = e0_reg.screen_y;

    a_launch_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
        launched_reg |-> (state_reg == ST_AVGX || state_reg == ST_AVGY
                          || state_reg == ST_MAPC || state_reg == ST_MAPR))
        else $error("Arithmetic request pending outside a compute state.");

    a_done_requested: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> launched_reg)
        else $error("Arithmetic result arrived without a request.");

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_reg < CW'(AVG_SAMPLES))
        else $error("Pair count passed the sample count.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2 || pop))
        else $error("Word pushed into a full output queue.");

endmodule

### dv/tb_touch_sample_sequencer_top.sv
module tb_touch_sample_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_PRESSURE,
        TP_XREAD,
        TP_YREAD
    } touch_phase_t;

    typedef struct {
        logic        op;
        logic        pen_n;
        logic [15:0] word;
        int unsigned gap;
    } touch_word_t;

    localparam int NUM_CAL_REGS = 7;
    localparam int READS_PER_TOUCH = 2 * DEF_AVG_SAMPLES;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [REG_W-1:0] SAMPLE_TOP = 12'hFFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 op = OP_POLL;
    logic                 pen_irq_n = 1'b1;
    logic [15:0]          reply_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 cmd_valid;
    logic [CMD_W-1:0]     cmd_byte;
    logic                 event_valid;
    logic                 pressed;
    logic [REG_W-1:0]     screen_x;
    logic [REG_W-1:0]     screen_y;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;

    touch_phase_t    tp_phase = TP_IDLE;
    int unsigned     pairs_done = 0;
    int unsigned     xchan_total = 0;
    int unsigned     ychan_total = 0;
    logic [REG_W-1:0] cal_regs [NUM_CAL_REGS];

    touch_word_t pending_words [$];
    res_t        expected_results [$];
    int          fail_count = 0;
    int unsigned words_queued = 0;
    bit          send_steady = 1'b0;

    touch_word_t drv_cur;
    bit          drv_staged = 1'b0;
    int unsigned drv_wait = 0;

    int unsigned mon_wait = 0;
    int unsigned hold_left = 0;
    int unsigned words_seen = 0;
    bit          recv_steady = 1'b0;

    touch_sample_sequencer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pen_irq_n   (pen_irq_n),
        .reply_word  (reply_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd_valid   (cmd_valid),
        .cmd_byte    (cmd_byte),
        .event_valid (event_valid),
        .pressed     (pressed),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("[touch_sample_sequencer_top] ERROR");
        $finish;
    end

    function automatic logic [REG_W-1:0] scale_to_screen(input int unsigned v,
                                                         input int unsigned lo,
                                                         input int unsigned hi,
                                                         input int unsigned top);
        if (v <= lo)
            return '0;
        if (v >= hi)
            return REG_W'(top);
        return REG_W'((v - lo) * top / (hi - lo));
    endfunction

    task automatic predict_touch(input logic op_i, input logic pen_i, input logic [15:0] word_i);
        res_t        r;
        int unsigned s;
        int unsigned avg_x;
        int unsigned avg_y;
        r = '0;
        s = word_i[14:3];
        if (op_i == OP_POLL) begin
            if (tp_phase != TP_IDLE) begin
                tp_phase = TP_IDLE;
            end else if (pen_i) begin
                r.event_valid = 1'b1;
            end else begin
                r.cmd_valid = 1'b1;
                r.cmd_byte = CMD_PRESSURE;
                tp_phase = TP_PRESSURE;
            end
        end else begin
            case (tp_phase)
                TP_PRESSURE:
                begin
                    if (s < cal_regs[REG_THRESHOLD]) begin
                        r.event_valid = 1'b1;
                        tp_phase = TP_IDLE;
                    end else begin
                        pairs_done = 0;
                        xchan_total = 0;
                        ychan_total = 0;
                        r.cmd_valid = 1'b1;
                        r.cmd_byte = CMD_XCHAN;
                        tp_phase = TP_XREAD;
                    end
                end
                TP_XREAD:
                begin
                    xchan_total += s;
                    r.cmd_valid = 1'b1;
                    r.cmd_byte = CMD_YCHAN;
                    tp_phase = TP_YREAD;
                end
                TP_YREAD:
                begin
                    ychan_total += s;
                    pairs_done++;
                    if (pairs_done >= DEF_AVG_SAMPLES) begin
                        avg_x = xchan_total / DEF_AVG_SAMPLES;
                        avg_y = ychan_total / DEF_AVG_SAMPLES;
                        r.event_valid = 1'b1;
                        r.pressed = 1'b1;
                        r.screen_x = scale_to_screen(avg_y, cal_regs[REG_YCHAN_MIN],
                                                     cal_regs[REG_YCHAN_MAX],
                                                     cal_regs[REG_COL_MAX]);
                        r.screen_y = scale_to_screen(avg_x, cal_regs[REG_XCHAN_MIN],
                                                     cal_regs[REG_XCHAN_MAX],
                                                     cal_regs[REG_ROW_MAX]);
                        tp_phase = TP_IDLE;
                        pairs_done = 0;
                    end else begin
                        r.cmd_valid = 1'b1;
                        r.cmd_byte = CMD_XCHAN;
                        tp_phase = TP_XREAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        res_t want;
        if (expected_results.size() == 0) begin
            $error("output word with no expectation: cmd_valid %0d cmd_byte %0h event_valid %0d",
                   cmd_valid, cmd_byte, event_valid);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("cmd_valid", want.cmd_valid, cmd_valid);
            compare_field("cmd_byte", want.cmd_byte, cmd_byte);
            compare_field("event_valid", want.event_valid, event_valid);
            compare_field("pressed", want.pressed, pressed);
            compare_field("screen_x", want.screen_x, screen_x);
            compare_field("screen_y", want.screen_y, screen_y);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            drv_staged = 1'b0;
            drv_wait = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_touch(op, pen_irq_n, reply_word);
                drv_staged = 1'b0;
            end
            if (!drv_staged && pending_words.size() != 0) begin
                drv_cur = pending_words.pop_front();
                drv_wait = drv_cur.gap;
                drv_staged = 1'b1;
            end
            if (drv_staged && drv_wait == 0) begin
                in_valid <= 1'b1;
                op <= drv_cur.op;
                pen_irq_n <= drv_cur.pen_n;
                reply_word <= drv_cur.word;
            end else begin
                in_valid <= 1'b0;
                if (drv_staged)
                    drv_wait--;
            end
        end
    end

    // The receiver stops taking words for a long stretch twice, so the output
    // queue fills and the block has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            mon_wait = 0;
            hold_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                check_result();
                words_seen++;
                if ($urandom_range(0, 39) == 0)
                    recv_steady = !recv_steady;
                mon_wait = recv_steady ? 0 : $urandom_range(0, 7);
                if (words_seen == 30 || words_seen == 600)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (mon_wait != 0) begin
                mon_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(input logic op_i, input logic pen_i, input logic [15:0] word_i);
        touch_word_t w;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        w.op = op_i;
        w.pen_n = pen_i;
        w.word = word_i;
        w.gap = send_steady ? 0 : $urandom_range(0, 7);
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [15:0] sample_word(input logic [REG_W-1:0] s);
        return {1'($urandom), s, 3'($urandom)};
    endfunction

    function automatic logic [REG_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return SAMPLE_TOP;
        return REG_W'($urandom_range(0, 4095));
    endfunction

    // Mostly complete touches with random readings; the rest are touches cut
    // short by a poll, and stray words.
    task automatic queue_touch_traffic(input int unsigned count);
        int unsigned      start;
        int unsigned      pick;
        int unsigned      n_reads;
        logic [REG_W-1:0] press;
        start = words_queued;
        while (words_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                push_word(OP_POLL, 1'b0, 16'($urandom));
                if ($urandom_range(0, 9) < 8)
                    press = REG_W'($urandom_range(cal_regs[REG_THRESHOLD], 4095));
                else
                    press = random_sample();
                push_word(OP_REPLY, 1'($urandom), sample_word(press));
                n_reads = (pick < 70) ? READS_PER_TOUCH : $urandom_range(0, READS_PER_TOUCH - 1);
                repeat (n_reads)
                    push_word(OP_REPLY, 1'($urandom), sample_word(random_sample()));
                if (pick >= 70)
                    push_word(OP_POLL, 1'($urandom), 16'($urandom));
            end else begin
                push_word(1'($urandom), 1'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic wait_until_drained();
        while (pending_words.size() != 0 || drv_staged || in_valid
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < NUM_CAL_REGS)
            cal_regs[idx] = value;
    endtask

    task automatic set_calibration(input logic [REG_W-1:0] thr,
                                   input logic [REG_W-1:0] x_lo, input logic [REG_W-1:0] x_hi,
                                   input logic [REG_W-1:0] y_lo, input logic [REG_W-1:0] y_hi,
                                   input logic [REG_W-1:0] col_top,
                                   input logic [REG_W-1:0] row_top);
        write_cal(REG_THRESHOLD, thr);
        write_cal(REG_XCHAN_MIN, x_lo);
        write_cal(REG_XCHAN_MAX, x_hi);
        write_cal(REG_YCHAN_MIN, y_lo);
        write_cal(REG_YCHAN_MAX, y_hi);
        write_cal(REG_COL_MAX, col_top);
        write_cal(REG_ROW_MAX, row_top);
    endtask

    initial
    begin
        int unsigned lo_x;
        int unsigned lo_y;
        cal_regs[REG_THRESHOLD] = RST_THRESHOLD;
        cal_regs[REG_XCHAN_MIN] = RST_RAW_MIN;
        cal_regs[REG_XCHAN_MAX] = RST_RAW_MAX;
        cal_regs[REG_YCHAN_MIN] = RST_RAW_MIN;
        cal_regs[REG_YCHAN_MAX] = RST_RAW_MAX;
        cal_regs[REG_COL_MAX] = RST_COL_MAX;
        cal_regs[REG_ROW_MAX] = RST_ROW_MAX;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // A reply with nothing pending, then a pen-up poll.
        push_word(OP_REPLY, 1'b0, 16'hFFFF);
        push_word(OP_POLL, 1'b1, 16'h0000);
        // Pressure one below the threshold is a light touch.
        push_word(OP_POLL, 1'b0, 16'h0000);
        push_word(OP_REPLY, 1'b1, {1'b0, RST_THRESHOLD - 12'd1, 3'b000});
        // Polls during a sequence abort it, even with the pen down.
        push_word(OP_POLL, 1'b0, 16'h0000);
        push_word(OP_POLL, 1'b0, 16'hFFFF);
        push_word(OP_POLL, 1'b0, 16'h0000);
        push_word(OP_REPLY, 1'b0, 16'hFFFF);
        push_word(OP_REPLY, 1'b0, 16'h0000);
        push_word(OP_POLL, 1'b0, 16'h0000);
        // Pressure exactly at the threshold, then readings at both extremes.
        push_word(OP_POLL, 1'b0, 16'h0000);
        push_word(OP_REPLY, 1'b0, {1'b1, RST_THRESHOLD, 3'b111});
        repeat (DEF_AVG_SAMPLES)
        begin
            push_word(OP_REPLY, 1'b1, 16'hFFFF);
            push_word(OP_REPLY, 1'b0, 16'h0000);
        end
        queue_touch_traffic(150);
        wait_until_drained();

        set_calibration(12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095);
        queue_touch_traffic(150);
        wait_until_drained();

        // Empty spans: one inverted, one zero-width, with zero screen sizes.
        set_calibration(12'd4095, 12'd3000, 12'd1000, 12'd2048, 12'd2048, 12'd0, 12'd0);
        write_cal(REG_UNUSED, 12'hFFF);
        queue_touch_traffic(100);
        wait_until_drained();

        set_calibration(12'd1, 12'd1000, 12'd1002, 12'd4094, 12'd4095, 12'd1, 12'd4095);
        queue_touch_traffic(100);
        wait_until_drained();

        repeat (2)
        begin
            lo_x = $urandom_range(0, 1500);
            lo_y = $urandom_range(0, 1500);
            set_calibration(REG_W'($urandom_range(0, 600)),
                            REG_W'(lo_x), REG_W'($urandom_range(lo_x + 1, 4095)),
                            REG_W'(lo_y), REG_W'($urandom_range(lo_y + 1, 4095)),
                            REG_W'($urandom_range(0, 4095)), REG_W'($urandom_range(0, 4095)));
            queue_touch_traffic(150);
            wait_until_drained();
        end

        repeat (2)
        begin
            set_calibration(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                            REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                            REG_W'($urandom));
            queue_touch_traffic(150);
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[touch_sample_sequencer_top] OK");
        else
            $display("[touch_sample_sequencer_top] ERROR");
        $finish;
    end

endmodule
